[hdl/psqe_pkg.sv]
// Shared constants for the polyline segment quad expander.
`default_nettype none

package psqe_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;

	localparam int CORNER_W = 3;
	localparam logic [CORNER_W-1:0] FIRST_CORNER = 3'd0;
	localparam logic [CORNER_W-1:0] LAST_CORNER  = 3'd5;

	// Per corner, bit k: vertex k sits on the segment end point b (else on a).
	localparam logic [5:0] CORNER_ON_B = 6'b110100;
	// Per corner, bit k: vertex k adds the normal (else subtracts it).
	localparam logic [5:0] CORNER_PLUS = 6'b011010;

endpackage

`default_nettype wire

[hdl/psqe_if.sv]
// Point and vertex stream interfaces for the quad expander.
`default_nettype none

interface psqe_point_if #(
	parameter int COORD_BITS = psqe_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic                         start_of_line;

	modport source(output valid, point_x, point_y, start_of_line, input ready);
	modport sink(input valid, point_x, point_y, start_of_line, output ready);
endinterface

interface psqe_vertex_if #(
	parameter int COORD_BITS = psqe_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = psqe_pkg::FRAC_BITS_DEF
);
	localparam int OUT_W = COORD_BITS + FRAC_BITS + 1;

	logic                              valid;
	logic                              ready;
	logic signed [OUT_W-1:0]           vertex_x;
	logic signed [OUT_W-1:0]           vertex_y;
	logic [psqe_pkg::CORNER_W-1:0]     corner;
	logic                              last_vertex;

	modport source(output valid, vertex_x, vertex_y, corner, last_vertex, input ready);
	modport sink(input valid, vertex_x, vertex_y, corner, last_vertex, output ready);
endinterface

`default_nettype wire

[hdl/psqe_norm.sv]
// Iterative normal magnitude unit: round(mag * 2^(F-1) / sqrt(mx^2 + my^2)) per axis.
`default_nettype none

module psqe_norm #(
	parameter int COORD_BITS = psqe_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = psqe_pkg::FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [COORD_BITS-1:0] mag_x,
	input  wire logic [COORD_BITS-1:0] mag_y,
	output logic                       done,
	output logic [FRAC_BITS-1:0]       q_x,
	output logic [FRAC_BITS-1:0]       q_y
);

	localparam int SQW  = 2 * COORD_BITS;
	localparam int SUMW = SQW + 1;
	localparam int REMW = SUMW + 1;
	localparam int QB   = 2 * FRAC_BITS + 1;
	localparam int SW   = FRAC_BITS + 1;
	localparam int PW   = 2 * SW;
	localparam int UW   = (REMW > PW) ? REMW : PW;
	localparam int CW   = $clog2(QB);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SQ   = 3'd1;
	localparam logic [2:0] S_SUM  = 3'd2;
	localparam logic [2:0] S_INIT = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_SQRT = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0]       state_q;
	logic [SQW-1:0]   sqx_q, sqy_q;
	logic [SUMW-1:0]  sum_q;
	logic [REMW-1:0]  rem_q;
	logic [QB-1:0]    quo_q;
	logic [SW-1:0]    root_q;
	logic [CW-1:0]    cnt_q;
	logic             comp_q;
	logic [FRAC_BITS-1:0] qx_q, qy_q;

	logic [SW-1:0]    cand;
	logic [PW-1:0]    cand_sq;
	logic [UW-1:0]    op_a, op_b, diff;
	logic             geq;
	logic [REMW-1:0]  rem_next;
	logic [SW-1:0]    root_next;
	logic [SW:0]      root_inc;

	// Square root trial: set the current bit and square it.
	assign cand    = root_q | ({{(SW-1){1'b0}}, 1'b1} << cnt_q);
	assign cand_sq = {{SW{1'b0}}, cand} * {{SW{1'b0}}, cand};

	// Shared compare/subtract: division step or square root trial.
	always_comb begin
		if (state_q == S_DIV) begin
			op_a = UW'(rem_q);
			op_b = UW'(sum_q);
		end else begin
			op_a = UW'(quo_q);
			op_b = UW'(cand_sq);
		end
	end
	assign geq  = op_a >= op_b;
	assign diff = op_a - op_b;

	assign rem_next  = geq ? diff[REMW-1:0] : rem_q;
	assign root_next = geq ? cand : root_q;
	// largest odd o with o*o <= D is root or root-1; q = (o+1)/2
	assign root_inc  = {1'b0, root_next} + {{SW{1'b0}}, 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			comp_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_SQ;
				end
				S_SQ: begin
					if (mag_x == '0 && mag_y == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					comp_q  <= 1'b0;
					state_q <= S_INIT;
				end
				S_INIT: begin
					cnt_q   <= CW'(QB - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						cnt_q   <= CW'(FRAC_BITS);
						state_q <= S_SQRT;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_SQRT: begin
					if (cnt_q == '0) begin
						comp_q  <= 1'b1;
						state_q <= comp_q ? S_DONE : S_INIT;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_SQ: begin
				sqx_q <= {{COORD_BITS{1'b0}}, mag_x} * {{COORD_BITS{1'b0}}, mag_x};
				sqy_q <= {{COORD_BITS{1'b0}}, mag_y} * {{COORD_BITS{1'b0}}, mag_y};
				qx_q  <= '0;
				qy_q  <= '0;
			end
			S_SUM: begin
				sum_q <= {1'b0, sqx_q} + {1'b0, sqy_q};
			end
			S_INIT: begin
				rem_q <= REMW'(comp_q ? sqx_q : sqy_q);
			end
			S_DIV: begin
				quo_q <= {quo_q[QB-2:0], geq};
				rem_q <= {rem_next[REMW-2:0], 1'b0};
				root_q <= '0;
			end
			S_SQRT: begin
				root_q <= root_next;
				if (cnt_q == '0) begin
					if (comp_q) begin
						qx_q <= root_inc[FRAC_BITS:1];
					end else begin
						qy_q <= root_inc[FRAC_BITS:1];
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign done = state_q == S_DONE;
	assign q_x  = qx_q;
	assign q_y  = qy_q;

endmodule

`default_nettype wire

[hdl/polyline_segment_quad_expander.sv]
// Polyline segment quad expander: a point that starts a line is taken and only stored.
// A segment point first runs through the shared compare/subtract unit, which steps
// the quotient and square-root bits, then the expander loads six vertices, one per
// cycle while the sink takes them.
// Input is ready again once the sixth vertex sits in the output register.
// Reset clears the stored-point flag, both sequencers and the output valid.
`default_nettype none

module polyline_segment_quad_expander #(
	parameter int COORD_BITS = psqe_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = psqe_pkg::FRAC_BITS_DEF
) (
	input wire logic       clk,
	input wire logic       arst_n,
	psqe_point_if.sink     point,
	psqe_vertex_if.source  vertex
);

	import psqe_pkg::*;

	localparam int OW = COORD_BITS + FRAC_BITS + 1;

	localparam logic [1:0] T_IDLE = 2'd0;
	localparam logic [1:0] T_CALC = 2'd1;
	localparam logic [1:0] T_EMIT = 2'd2;

	logic [1:0]            state_q;
	logic                  have_prev_q;
	logic [COORD_BITS-1:0] prev_x_q, prev_y_q;
	logic [COORD_BITS-1:0] a_x_q, a_y_q;
	logic [COORD_BITS-1:0] mag_x_q, mag_y_q;
	logic                  neg_dx_q, neg_dy_q;
	logic [CORNER_W-1:0]   corner_q;

	logic                  ovalid_q;
	logic [OW-1:0]         vx_q, vy_q;
	logic [CORNER_W-1:0]   ocorner_q;
	logic                  olast_q;

	logic                  accept, segment, norm_done;
	logic [COORD_BITS:0]   dx, dy, abs_dx, abs_dy;
	logic [FRAC_BITS-1:0]  q_x, q_y;
	logic [OW-1:0]         qx_ext, qy_ext, nx, ny, px, py, vx_next, vy_next;
	logic [COORD_BITS-1:0] sel_x, sel_y;
	logic                  out_load;

	assign point.ready = state_q == T_IDLE;
	assign accept      = point.valid && point.ready;
	assign segment     = point.start_of_line == 1'b0 && have_prev_q;

	assign dx     = {point.point_x[COORD_BITS-1], point.point_x} -
	                {prev_x_q[COORD_BITS-1], prev_x_q};
	assign dy     = {point.point_y[COORD_BITS-1], point.point_y} -
	                {prev_y_q[COORD_BITS-1], prev_y_q};
	assign abs_dx = dx[COORD_BITS] ? -dx : dx;
	assign abs_dy = dy[COORD_BITS] ? -dy : dy;

	psqe_norm #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_norm (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept && segment),
		.mag_x (mag_x_q),
		.mag_y (mag_y_q),
		.done  (norm_done),
		.q_x   (q_x),
		.q_y   (q_y)
	);

	// n = (-dy, dx) direction, magnitudes from the norm unit
	assign qx_ext = {{(OW-FRAC_BITS){1'b0}}, q_x};
	assign qy_ext = {{(OW-FRAC_BITS){1'b0}}, q_y};
	assign nx     = neg_dy_q ? qy_ext : -qy_ext;
	assign ny     = neg_dx_q ? -qx_ext : qx_ext;

	// prev_*_q holds the segment end point b while emitting
	assign sel_x   = CORNER_ON_B[corner_q] ? prev_x_q : a_x_q;
	assign sel_y   = CORNER_ON_B[corner_q] ? prev_y_q : a_y_q;
	assign px      = {sel_x[COORD_BITS-1], sel_x, {FRAC_BITS{1'b0}}};
	assign py      = {sel_y[COORD_BITS-1], sel_y, {FRAC_BITS{1'b0}}};
	assign vx_next = CORNER_PLUS[corner_q] ? px + nx : px - nx;
	assign vy_next = CORNER_PLUS[corner_q] ? py + ny : py - ny;

	assign out_load = state_q == T_EMIT && (!ovalid_q || vertex.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			have_prev_q <= 1'b0;
			corner_q    <= FIRST_CORNER;
			ovalid_q    <= 1'b0;
		end else begin
			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						have_prev_q <= 1'b1;
						if (segment) state_q <= T_CALC;
					end
				end
				T_CALC: begin
					if (norm_done) begin
						corner_q <= FIRST_CORNER;
						state_q  <= T_EMIT;
					end
				end
				T_EMIT: begin
					if (out_load) begin
						corner_q <= corner_q + 1'b1;
						if (corner_q == LAST_CORNER) state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase

			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (vertex.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
		end else if (accept) begin
			prev_x_q <= point.point_x;
			prev_y_q <= point.point_y;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_x_q    <= prev_x_q;
			a_y_q    <= prev_y_q;
			mag_x_q  <= abs_dx[COORD_BITS-1:0];
			mag_y_q  <= abs_dy[COORD_BITS-1:0];
			neg_dx_q <= dx[COORD_BITS];
			neg_dy_q <= dy[COORD_BITS];
		end
		if (out_load) begin
			vx_q      <= vx_next;
			vy_q      <= vy_next;
			ocorner_q <= corner_q;
			olast_q   <= corner_q == LAST_CORNER;
		end
	end

	assign vertex.valid       = ovalid_q;
	assign vertex.vertex_x    = vx_q;
	assign vertex.vertex_y    = vy_q;
	assign vertex.corner      = ocorner_q;
	assign vertex.last_vertex = olast_q;

endmodule

`default_nettype wire
